// ===== rtl/idn_pkg.sv =====
// Shared types, constants and helpers for the IMEI digit normaliser.
`timescale 1ns / 1ps

package idn_pkg;

  localparam int NUM_DIGITS    = 16;  // digit store depth
  localparam int COUNT_SAT     = 17;  // count holds here once past the store
  localparam int LUHN_DIGITS   = 14;
  localparam int TAC_DIGITS    = 8;
  localparam int SERIAL_DIGITS = 6;
  localparam int RADIX         = 10;
  localparam int MAX_DIGIT     = 9;

  localparam int CNT_W    = $clog2(COUNT_SAT + 1);
  localparam int IDX_W    = $clog2(NUM_DIGITS);
  localparam int IMEI_W   = 4 * LUHN_DIGITS;
  localparam int TAC_W    = 4 * TAC_DIGITS;
  localparam int SERIAL_W = 4 * SERIAL_DIGITS;
  localparam int VER_W    = 8;

  localparam logic [3:0] FILLER_NIB = 4'hF;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  localparam logic FMT_TEXT = 1'b0;
  localparam logic FMT_BCD  = 1'b1;

  localparam logic [1:0] KIND_INVALID  = 2'd0;
  localparam logic [1:0] KIND_FOURTEEN = 2'd1;
  localparam logic [1:0] KIND_FIFTEEN  = 2'd2;
  localparam logic [1:0] KIND_SIXTEEN  = 2'd3;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    SK_SKIP,
    SK_TEXT_DIG,
    SK_NIB_DIG,
    SK_FILLER,
    SK_BAD
  } slot_kind_t;

  typedef struct packed {
    slot_kind_t kind;
    logic [3:0] value;
  } slot_t;

  // one classified byte: up to two nibble slots, low nibble first
  typedef struct packed {
    slot_t s0;
    slot_t s1;
    logic  last;
  } qitem_t;

  // Luhn doubling of a digit on odd positions
  function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
    logic [4:0] t;
    begin
      t = {d, 1'b0};
      if (t > 5'(MAX_DIGIT)) begin
        t = t - 5'(MAX_DIGIT);
      end
      return t[3:0];
    end
  endfunction

endpackage

// ===== rtl/idn_in_if.sv =====
// Input byte channel.
`timescale 1ns / 1ps

interface idn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// ===== rtl/idn_out_if.sv =====
// Result channel.
`timescale 1ns / 1ps

interface idn_out_if
  import idn_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [1:0]          format_kind;
  logic [IMEI_W-1:0]   imei_digits;
  logic [TAC_W-1:0]    tac_digits;
  logic [SERIAL_W-1:0] serial_digits;
  logic [VER_W-1:0]    version_digits;
  logic                check_ok;

  modport source (output valid, output format_kind, output imei_digits, output tac_digits,
                  output serial_digits, output version_digits, output check_ok,
                  input ready);
  modport sink   (input valid, input format_kind, input imei_digits, input tac_digits,
                  input serial_digits, input version_digits, input check_ok,
                  output ready);
endinterface

// ===== rtl/idn_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps

interface idn_cfg_if;
  logic valid;
  logic ready;
  logic input_format;

  modport source (output valid, output input_format, input ready);
  modport sink   (input valid, input input_format, output ready);
endinterface

// ===== rtl/imei_digit_normalizer_top.sv =====
// Top level of the IMEI digit normaliser.
`timescale 1ns / 1ps

// Takes one byte a cycle and gives one result on the byte marked last. The
// front end classifies each byte (ASCII digit, or two BCD nibbles low then
// high) and writes it into a two-entry queue; the back end drains one item
// a cycle, keeps the first sixteen digits and a running Luhn sum, and on the
// last byte loads the result register. The back end stalls only when a last
// byte finds the result register still full, and the queue then fills; the
// input keeps its one-item-a-cycle rate while the result channel keeps up.
// input_format is to be written through the cfg channel only while the block
// is idle; the block itself does not enforce this.
module imei_digit_normalizer_top
  import idn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  idn_cfg_if.sink   cfg_if,
  idn_in_if.sink    in_if,
  idn_out_if.source out_if
);

  logic   q_full;
  logic   push;
  qitem_t push_item;
  logic   pop;
  logic   head_valid;
  qitem_t head_item;

  idn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_if    (cfg_if),
    .in_if     (in_if),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  idn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  idn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_if     (out_if)
  );

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.format_kind == KIND_INVALID)) |->
      ((out_if.imei_digits == '0) && (out_if.version_digits == '0) && !out_if.check_ok))
    else $error("invalid record carries non-zero digits");

  a_check_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.check_ok) |-> (out_if.format_kind == KIND_FIFTEEN))
    else $error("check flag set on a record without a check digit");

  a_version_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.version_digits != '0)) |-> (out_if.format_kind == KIND_SIXTEEN))
    else $error("version digits on a record that is not sixteen digits");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("back end took an item from an empty queue");

endmodule

// ===== rtl/idn_front.sv =====
// Front end: format register and per-byte classification (ASCII digit or BCD nibbles).
`timescale 1ns / 1ps

module idn_front
  import idn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  idn_cfg_if.sink     cfg_if,
  idn_in_if.sink      in_if,
  input  logic        q_full,
  output logic        push,
  output qitem_t      push_item
);

  logic fmt_r, fmt_nxt;

  function automatic slot_t nib_class(input logic [3:0] n);
    slot_t s;
    begin
      s.value = n;
      if (n == FILLER_NIB) begin
        s.kind = SK_FILLER;
      end else if (n > 4'(MAX_DIGIT)) begin
        s.kind = SK_BAD;
      end else begin
        s.kind = SK_NIB_DIG;
      end
      return s;
    end
  endfunction

  assign cfg_if.ready = 1'b1;

  always_comb begin
    fmt_nxt = fmt_r;
    if (cfg_if.valid) begin
      fmt_nxt = cfg_if.input_format;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_TEXT;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  always_comb begin
    push_item.last     = in_if.is_last;
    push_item.s1.kind  = SK_SKIP;
    push_item.s1.value = in_if.data_byte[7:4];
    push_item.s0.value = in_if.data_byte[3:0];
    push_item.s0.kind  = SK_SKIP;
    if (fmt_r == FMT_BCD) begin
      push_item.s0 = nib_class(in_if.data_byte[3:0]);
      push_item.s1 = nib_class(in_if.data_byte[7:4]);
    end else if (in_if.data_byte inside {[ASCII_ZERO:ASCII_NINE]}) begin
      push_item.s0.kind = SK_TEXT_DIG;
    end
  end

endmodule

// ===== rtl/idn_queue.sv =====
// Short item queue between front and back end.
`timescale 1ns / 1ps

module idn_queue
  import idn_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output qitem_t head_item
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int OCC_W = $clog2(QDEPTH + 1);

  qitem_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;

  assign full       = (occ_r == OCC_W'(QDEPTH));
  assign head_valid = (occ_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (pop && !push) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/idn_back.sv =====
// Back end: digit store, Luhn accumulation and result register.
`timescale 1ns / 1ps

module idn_back
  import idn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  qitem_t    head_item,
  output logic      pop,
  idn_out_if.source out_if
);

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [3:0]       residue;
    logic             bad;
    logic             filler;
  } acc_t;

  typedef struct packed {
    acc_t             acc;
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [3:0]       digit;
  } step_t;

  function automatic step_t take_slot(input acc_t a, input slot_t s);
    step_t      r;
    logic       stop;
    logic       take;
    logic [3:0] v;
    logic [4:0] sum;
    begin
      r.acc   = a;
      r.we    = 1'b0;
      r.addr  = a.count[IDX_W-1:0];
      r.digit = s.value;
      stop    = a.bad || a.filler;
      // text digits are kept even after a filler from an earlier BCD byte
      take    = (s.kind == SK_TEXT_DIG) || ((s.kind == SK_NIB_DIG) && !stop);
      v       = a.count[0] ? luhn_dbl(s.value) : s.value;
      sum     = {1'b0, a.residue} + {1'b0, v};
      if (take) begin
        if (a.count < CNT_W'(LUHN_DIGITS)) begin
          r.acc.residue = (sum >= 5'(RADIX)) ? 4'(sum - 5'(RADIX)) : sum[3:0];
        end
        r.we = (a.count < CNT_W'(NUM_DIGITS));
        if (a.count < CNT_W'(COUNT_SAT)) begin
          r.acc.count = a.count + CNT_W'(1);
        end
      end
      if (!stop && (s.kind == SK_FILLER)) begin
        r.acc.filler = 1'b1;
      end
      if (!stop && (s.kind == SK_BAD)) begin
        r.acc.bad = 1'b1;
      end
      return r;
    end
  endfunction

  acc_t       acc_r, acc_nxt;
  logic [3:0] store_r   [NUM_DIGITS];
  logic [3:0] store_nxt [NUM_DIGITS];
  step_t      st0, st1;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [IMEI_W-1:0]   imei_r, imei_nxt;
  logic [VER_W-1:0]    ver_r, ver_nxt;
  logic                chk_r, chk_nxt;
  logic [3:0]          expect_dig;
  logic                emit;

  // a non-last item never waits for the result register
  assign pop  = head_valid && (!head_item.last || !out_valid_r || out_if.ready);
  assign emit = pop && head_item.last;

  always_comb begin
    st0 = take_slot(acc_r, head_item.s0);
    st1 = take_slot(st0.acc, head_item.s1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      store_nxt[i] = store_r[i];
      if (st0.we && (st0.addr == IDX_W'(i))) begin
        store_nxt[i] = st0.digit;
      end
      if (st1.we && (st1.addr == IDX_W'(i))) begin
        store_nxt[i] = st1.digit;
      end
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (pop) begin
      acc_nxt = emit ? '0 : st1.acc;
    end
  end

  always_comb begin
    kind_nxt = KIND_INVALID;
    if (!st1.acc.bad) begin
      if (st1.acc.count == CNT_W'(LUHN_DIGITS)) begin
        kind_nxt = KIND_FOURTEEN;
      end else if (st1.acc.count == CNT_W'(LUHN_DIGITS + 1)) begin
        kind_nxt = KIND_FIFTEEN;
      end else if (st1.acc.count == CNT_W'(NUM_DIGITS)) begin
        kind_nxt = KIND_SIXTEEN;
      end
    end
    expect_dig = (st1.acc.residue == 4'd0) ? 4'd0 : 4'(RADIX) - st1.acc.residue;
    imei_nxt = '0;
    if (kind_nxt != KIND_INVALID) begin
      for (int i = 0; i < LUHN_DIGITS; i++) begin
        imei_nxt[IMEI_W-1-4*i -: 4] = store_nxt[i];
      end
    end
    ver_nxt = (kind_nxt == KIND_SIXTEEN) ?
              {store_nxt[LUHN_DIGITS], store_nxt[LUHN_DIGITS+1]} : '0;
    chk_nxt = (kind_nxt == KIND_FIFTEEN) && (store_nxt[LUHN_DIGITS] == expect_dig);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
    if (emit) begin
      kind_r <= kind_nxt;
      imei_r <= imei_nxt;
      ver_r  <= ver_nxt;
      chk_r  <= chk_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.format_kind    = kind_r;
  assign out_if.imei_digits    = imei_r;
  assign out_if.tac_digits     = imei_r[IMEI_W-1 -: TAC_W];
  assign out_if.serial_digits  = imei_r[SERIAL_W-1:0];
  assign out_if.version_digits = ver_r;
  assign out_if.check_ok       = chk_r;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the IMEI digit normaliser: directed records, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import idn_pkg::*;

  localparam int MAX_WAIT        = 18;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int REPORT_LIMIT    = 10;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [IMEI_W-1:0]   imei;
    logic [TAC_W-1:0]    tac;
    logic [SERIAL_W-1:0] serial;
    logic [VER_W-1:0]    ver;
    logic                ok;
  } decode_t;

  // one directed record fragment; bytes read left to right in the literal
  typedef struct packed {
    logic        fmt;
    logic [3:0]  len;
    logic [71:0] bytes;
    logic        closes;
    logic        typed;
    decode_t     want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  idn_cfg_if cfg_ch();
  idn_in_if  in_ch();
  idn_out_if out_ch();

  imei_digit_normalizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_ch),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // shadow of the block's record state
  logic       fmt_now = FMT_TEXT;
  logic [3:0] kept_digits [NUM_DIGITS] = '{default: 4'h0};
  logic [4:0] kept_count = '0;
  logic       rec_bad = 1'b0;
  logic       rec_filler = 1'b0;
  logic [3:0] luhn_sum = '0;

  decode_t    pending_decodes [$];
  logic [7:0] rec_bytes [$];
  stim_row_t  dir_rows [8];

  idle_mode_t send_mode = IDLE_FULL;
  idle_mode_t recv_mode = IDLE_SPARSE;

  int errors = 0;
  int items_sent = 0;
  int records_sent = 0;
  int results_seen = 0;
  int format_writes = 0;
  int check_hits = 0;
  int kind_tally [4] = '{default: 0};
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles, %0d results outstanding", cycle_count,
             pending_decodes.size());
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int draw_wait(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, MAX_WAIT);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
    endcase
  endfunction

  function automatic void absorb_digit(input logic [3:0] d);
    int v;
    if (kept_count < LUHN_DIGITS) begin
      v = d;
      if (kept_count[0]) begin
        v = 2 * v;
        if (v > MAX_DIGIT) v -= MAX_DIGIT;
      end
      luhn_sum = 4'((luhn_sum + v) % RADIX);
    end
    if (kept_count < NUM_DIGITS) kept_digits[kept_count[3:0]] = d;
    if (kept_count < COUNT_SAT) kept_count++;
  endfunction

  function automatic void absorb_nibble(input logic [3:0] n);
    if (rec_filler || rec_bad) return;
    if (n == FILLER_NIB) rec_filler = 1'b1;
    else if (n > MAX_DIGIT) rec_bad = 1'b1;
    else absorb_digit(n);
  endfunction

  // advances the shadow state by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output decode_t r);
    int i;
    r = '0;
    if (fmt_now == FMT_TEXT) begin
      if (b >= ASCII_ZERO && b <= ASCII_NINE) absorb_digit(4'(b - ASCII_ZERO));
    end else begin
      absorb_nibble(b[3:0]);
      absorb_nibble(b[7:4]);
    end
    if (!last) return 1'b0;
    r.kind = KIND_INVALID;
    if (!rec_bad) begin
      if (kept_count == LUHN_DIGITS) r.kind = KIND_FOURTEEN;
      else if (kept_count == LUHN_DIGITS + 1) r.kind = KIND_FIFTEEN;
      else if (kept_count == NUM_DIGITS) r.kind = KIND_SIXTEEN;
    end
    if (r.kind != KIND_INVALID) begin
      for (i = 0; i < LUHN_DIGITS; i++) r.imei = {r.imei[IMEI_W-5:0], kept_digits[i]};
      // TAC is the head of the IMEI, serial its tail
      r.tac    = r.imei[IMEI_W-1 -: TAC_W];
      r.serial = r.imei[SERIAL_W-1:0];
      if (r.kind == KIND_SIXTEEN) r.ver = {kept_digits[14], kept_digits[15]};
      if (r.kind == KIND_FIFTEEN)
        r.ok = (kept_digits[14] == 4'((RADIX - luhn_sum) % RADIX));
    end
    kept_count = '0;
    rec_bad    = 1'b0;
    rec_filler = 1'b0;
    luhn_sum   = '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] stray_char();
    logic [7:0] b;
    b = 8'($urandom);
    if (b >= ASCII_ZERO && b <= ASCII_NINE) b ^= 8'h80;
    return b;
  endfunction

  // mostly well-formed records with random digits, some broken or pure noise
  function automatic void make_record(input logic f);
    logic [3:0] digs [$];
    logic [3:0] nibs [$];
    string      pfx;
    int         n, style, sum, v, k;
    rec_bytes.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      n = $urandom_range(1, 20);
      repeat (n) rec_bytes.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(0, 9))
      0:       n = $urandom_range(0, LUHN_DIGITS - 1);
      1:       n = $urandom_range(COUNT_SAT, 20);
      default: n = $urandom_range(LUHN_DIGITS, NUM_DIGITS);
    endcase
    repeat (n) digs.push_back(4'($urandom_range(0, MAX_DIGIT)));
    if (n == LUHN_DIGITS + 1 && $urandom_range(0, 1) == 1) begin
      sum = 0;
      for (k = 0; k < LUHN_DIGITS; k++) begin
        v = digs[k];
        if (k % 2 == 1) begin
          v = 2 * v;
          if (v > MAX_DIGIT) v -= MAX_DIGIT;
        end
        sum += v;
      end
      digs[LUHN_DIGITS] = 4'((RADIX - sum % RADIX) % RADIX);
    end
    if (f == FMT_TEXT) begin
      if (style == 1) begin
        pfx = "imei:";
        for (k = 0; k < pfx.len(); k++) rec_bytes.push_back(pfx[k]);
      end
      foreach (digs[j]) begin
        if ($urandom_range(0, 7) == 0) rec_bytes.push_back(stray_char());
        rec_bytes.push_back(ASCII_ZERO + 8'(digs[j]));
      end
      if ($urandom_range(0, 3) == 0) rec_bytes.push_back(stray_char());
    end else begin
      nibs = digs;
      if (style == 2 && nibs.size() != 0)
        nibs[$urandom_range(0, nibs.size() - 1)] = 4'($urandom_range(MAX_DIGIT + 1, 14));
      if (nibs.size() % 2 == 1 || $urandom_range(0, 2) == 0) begin
        nibs.push_back(FILLER_NIB);
        if (nibs.size() % 2 == 1) nibs.push_back(4'($urandom));
      end
      for (k = 0; k < nibs.size(); k += 2) rec_bytes.push_back({nibs[k+1], nibs[k]});
      if (style == 3) repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom));
    end
    if (rec_bytes.size() == 0) rec_bytes.push_back(stray_char());
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last, input logic typed,
                           input decode_t want);
    int      gap;
    decode_t r;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (decode_byte(b, last, r)) pending_decodes.push_back(typed ? want : r);
    items_sent++;
  endtask

  // stop sending until every result is back and the pipeline has emptied
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_decodes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input logic f);
    settle_block();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.input_format <= f;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    fmt_now = f;
    format_writes++;
  endtask

  initial begin : result_sink
    decode_t got, want;
    int      stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(recv_mode);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.format_kind, out_ch.imei_digits, out_ch.tac_digits,
              out_ch.serial_digits, out_ch.version_digits, out_ch.check_ok};
      results_seen++;
      kind_tally[got.kind]++;
      if (got.ok) check_hits++;
      if (pending_decodes.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("[%0t] result with none awaited: kind=%0d imei=%h", $realtime,
                   got.kind, got.imei);
      end else begin
        want = pending_decodes.pop_front();
        if (got.kind !== want.kind || got.imei !== want.imei || got.tac !== want.tac ||
            got.serial !== want.serial || got.ver !== want.ver || got.ok !== want.ok) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("[%0t] result %0d mismatch", $realtime, results_seen);
            $display("  expected kind=%0d imei=%h tac=%h sn=%h sv=%h chk=%b", want.kind,
                     want.imei, want.tac, want.serial, want.ver, want.ok);
            $display("  actual   kind=%0d imei=%h tac=%h sn=%h sv=%h chk=%b", got.kind,
                     got.imei, got.tac, got.serial, got.ver, got.ok);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int phase, r, i, phase_start, drain_wait;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= 8'h00;
    in_ch.is_last       <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.input_format <= FMT_TEXT;

    // text start "I:4901", then BCD for the rest: format switch inside a record
    dir_rows[0] = '{FMT_TEXT, 4'd6, 72'h49_3A_34_39_30_31, 1'b0, 1'b0, '0};
    dir_rows[1] = '{FMT_BCD, 4'd6, 72'h45_02_23_73_15_F8, 1'b1, 1'b1,
                    '{KIND_FIFTEEN, 56'h49015420323751, 32'h49015420, 24'h323751,
                      8'h00, 1'b1}};
    // lone filler, bad nibble
    dir_rows[2] = '{FMT_BCD, 4'd1, 72'hFF, 1'b1, 1'b1,
                    '{KIND_INVALID, '0, '0, '0, '0, 1'b0}};
    dir_rows[3] = '{FMT_BCD, 4'd1, 72'hA0, 1'b1, 1'b1,
                    '{KIND_INVALID, '0, '0, '0, '0, 1'b0}};
    dir_rows[4] = '{FMT_BCD, 4'd8, 72'h99_99_99_99_99_99_99_99, 1'b1, 1'b1,
                    '{KIND_SIXTEEN, 56'h99999999999999, 32'h99999999, 24'h999999,
                      8'h99, 1'b0}};
    // fourteen zeros, filler, then a bad nibble that must be ignored
    dir_rows[5] = '{FMT_BCD, 4'd8, 72'h00_00_00_00_00_00_00_AF, 1'b1, 1'b1,
                    '{KIND_FOURTEEN, '0, '0, '0, '0, 1'b0}};
    // eighteen digits: count saturates
    dir_rows[6] = '{FMT_BCD, 4'd9, 72'h11_11_11_11_11_11_11_11_11, 1'b1, 1'b1,
                    '{KIND_INVALID, '0, '0, '0, '0, 1'b0}};
    dir_rows[7] = '{FMT_TEXT, 4'd2, 72'h2F_3A, 1'b1, 1'b1,
                    '{KIND_INVALID, '0, '0, '0, '0, 1'b0}};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < 8; r++) begin
      if (r == 0 || dir_rows[r].fmt != fmt_now) set_format(dir_rows[r].fmt);
      for (i = 0; i < dir_rows[r].len; i++)
        push_byte(dir_rows[r].bytes[8 * (dir_rows[r].len - 1 - i) +: 8],
                  dir_rows[r].closes && i == dir_rows[r].len - 1,
                  dir_rows[r].typed, dir_rows[r].want);
      if (dir_rows[r].closes) records_sent++;
    end

    for (phase = 0; phase < PHASES; phase++) begin
      send_mode = idle_mode_t'(phase % 3);
      recv_mode = idle_mode_t'((phase + 1) % 3);
      set_format(phase % 2 == 1 ? FMT_BCD : FMT_TEXT);
      phase_start = items_sent;
      r = 0;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        make_record(fmt_now);
        if (r == 3) settle_block();
        foreach (rec_bytes[k])
          push_byte(rec_bytes[k], k == rec_bytes.size() - 1, 1'b0, '0);
        r++;
        records_sent++;
      end
    end

    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (pending_decodes.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_decodes.size() != 0)
      $display("%0d expected results never arrived", pending_decodes.size());
    errors += pending_decodes.size();

    $display("%0d items in %0d records, %0d format writes, %0d results checked, %0d errors",
             items_sent, records_sent, format_writes, results_seen, errors);
    $display("kinds seen: invalid %0d, fourteen %0d, fifteen %0d (%0d check ok), sixteen %0d",
             kind_tally[0], kind_tally[1], kind_tally[2], check_hits, kind_tally[3]);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
